// File: rtl/ght_pkg.sv
package ght_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 256;

    localparam int OP_W       = 3;
    localparam int HANDLE_W   = 32;
    localparam int KIND_W     = 8;
    localparam int GEN_W      = 16;
    localparam int NUM_W      = 16;
    localparam int MODE_W     = 2;
    localparam int WORD_W     = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
    localparam logic [OP_W-1:0] OP_PROMOTE = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_DECODE  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FREE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIVE     = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KIND_W-1:0] kind;
        logic [GEN_W-1:0]  gen;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic take;
        logic rd_slot;
        logic rd_hint;
        logic scan_next;
        logic found;
        logic fin_alloc;
        logic fin_exec;
        logic fin_plain;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_hvalid;
        logic in_kind_zero;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/generational_handle_table.sv
// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   handle[31:0], object_kind[39:32]                    opcode[2:0]
// m_axis    out  new_handle[31:0], slot_number[47:32],               status[0]
//                slot_status[49:48], zero pad[55:50]
//
// lookup, promote, release, decode, unused opcodes and a zero-kind allocate go from
// accept to result without a scan; allocate scans one bitmap word after another from
// the lowest word that may hold a free slot, 32 slots per word
// after reset a clearing pass over every slot runs before s_axis_tready rises
// one item is in flight at a time: a result waiting on m_axis holds the finishing
// step, and s_axis_tready stays low until that step is done
module generational_handle_table import ght_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // handle, object_kind
    input  logic [OP_W-1:0]       s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // new_handle, slot_number, slot_status
    output logic [0:0]            m_axis_tuser    // status
);

    t_cmd cmd;
    t_sts sts;

    logic                status;
    logic [HANDLE_W-1:0] new_handle;
    logic [NUM_W-1:0]    slot_number;
    logic [MODE_W-1:0]   slot_status;

    ght_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ght_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_handle      (s_axis_tdata[HANDLE_W-1:0]),
        .i_kind        (s_axis_tdata[HANDLE_W+KIND_W-1:HANDLE_W]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_new_handle  (new_handle),
        .o_slot_number (slot_number),
        .o_slot_status (slot_status)
    );

    assign m_axis_tdata = {6'd0, slot_status, slot_number, new_handle};
    assign m_axis_tuser = status;

endmodule

// File: rtl/ght_ctrl.sv
module ght_ctrl import ght_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_ready,
    input  t_sts            i_sts,
    output t_cmd            o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    priority if (i_op == OP_ALLOC) begin
                        if (i_sts.in_kind_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_hint = 1'b1;
                            n_state       = S_SCAN;
                        end
                    end else if (i_op == OP_LOOKUP || i_op == OP_PROMOTE ||
                                 i_op == OP_RELEASE) begin
                        if (i_sts.in_hvalid) begin
                            o_cmd.rd_slot = 1'b1;
                            n_state       = S_EXEC;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_sts.scan_hit) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_ALLOC;
                end else if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_ALLOC: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_alloc = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_exec = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_plain = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/ght_dp.sv
module ght_dp import ght_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [OP_W-1:0]     i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [KIND_W-1:0]   i_kind,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_status,
    output logic [HANDLE_W-1:0] o_new_handle,
    output logic [NUM_W-1:0]    o_slot_number,
    output logic [MODE_W-1:0]   o_slot_status
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WORDS = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WRD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SCN_W = $clog2(WORDS + 1);
    localparam logic [NUM_W-1:0] NONE_NUM = NUM_W'(SLOT_COUNT);

    // slot store and busy bitmap, cleared by a pass after reset
    t_slot             m_slot [SLOT_COUNT];
    logic [WORD_W-1:0] m_bmp  [WORDS];
    t_slot             r_slot_q;
    logic [WORD_W-1:0] r_bmp_q;

    logic [IDX_W-1:0]    r_clr;
    logic [SCN_W-1:0]    r_scan;
    logic [SCN_W-1:0]    r_hint;
    logic [OP_W-1:0]     r_op;
    logic [GEN_W-1:0]    r_gen;
    logic [KIND_W-1:0]   r_kind;
    logic                r_hvalid;
    logic [NUM_W-1:0]    r_num;
    logic                r_out_valid;
    logic                r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [NUM_W-1:0]    r_out_num;
    logic [MODE_W-1:0]   r_out_mode;

    // input handle decode
    logic [NUM_W-1:0] in_low;
    logic [GEN_W-1:0] in_gen;
    logic [NUM_W-1:0] in_idx;
    logic             in_hvalid;

    always_comb begin
        in_low    = i_handle[NUM_W-1:0];
        in_gen    = i_handle[HANDLE_W-1:NUM_W];
        in_idx    = in_low - NUM_W'(1);
        in_hvalid = (in_low != '0) && (in_low <= NONE_NUM) && (in_gen != '0);
    end

    // free slot search inside the current bitmap word
    logic [31:0]       scan_base;
    logic [31:0]       scan_rem;
    logic [WORD_W-1:0] scan_mask;
    logic [WORD_W-1:0] scan_free;
    logic [4:0]        scan_bit;
    logic [SCN_W-1:0]  scan_inc;
    logic [NUM_W-1:0]  found_num;

    always_comb begin
        scan_base = 32'(r_scan) << 5;
        scan_rem  = 32'(SLOT_COUNT) - scan_base;
        if (scan_rem >= 32'(WORD_W)) scan_mask = '1;
        else scan_mask = (WORD_W'(1) << scan_rem[4:0]) - WORD_W'(1);
        scan_free = ~r_bmp_q & scan_mask;
        scan_bit  = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (scan_free[b]) scan_bit = 5'(b);
        end
        scan_inc  = r_scan + SCN_W'(1);
        found_num = NUM_W'(scan_base | 32'(scan_bit));
    end

    // handle match and new slot values
    logic             match;
    logic [GEN_W-1:0] gen_alloc;
    logic [GEN_W-1:0] gen_inc;
    logic [GEN_W-1:0] gen_rel;
    logic [MODE_W-1:0] mode_prom;
    logic [WORD_W-1:0] num_bit;
    logic [SCN_W-1:0]  num_wrd;

    always_comb begin
        match     = (r_slot_q.mode != MODE_FREE) && (r_slot_q.gen == r_gen) &&
                    (r_slot_q.kind == r_kind);
        gen_alloc = (r_slot_q.gen == '0) ? GEN_W'(1) : r_slot_q.gen;
        gen_inc   = r_slot_q.gen + GEN_W'(1);
        gen_rel   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
        mode_prom = (r_slot_q.mode == MODE_RESERVED) ? MODE_LIVE : r_slot_q.mode;
        num_bit   = WORD_W'(1) << r_num[4:0];
        num_wrd   = SCN_W'(r_num >> 5);
    end

    // memory port control
    logic             slot_we;
    logic [IDX_W-1:0] slot_wa;
    t_slot            slot_wd;
    logic             slot_re;
    logic [IDX_W-1:0] slot_ra;
    logic              bmp_we;
    logic [WRD_W-1:0]  bmp_wa;
    logic [WORD_W-1:0] bmp_wd;
    logic              bmp_re;
    logic [WRD_W-1:0]  bmp_ra;
    logic              exec_wr;

    always_comb begin
        exec_wr = i_cmd.fin_exec && match &&
                  (r_op == OP_PROMOTE || r_op == OP_RELEASE);

        slot_we = 1'b0;
        slot_wa = r_num[IDX_W-1:0];
        slot_wd = '0;
        if (i_cmd.clr) begin
            slot_we = 1'b1;
            slot_wa = r_clr;
        end else if (i_cmd.fin_alloc) begin
            slot_we = 1'b1;
            slot_wd = '{mode: MODE_RESERVED, kind: r_kind, gen: gen_alloc};
        end else if (exec_wr) begin
            slot_we = 1'b1;
            if (r_op == OP_PROMOTE) begin
                slot_wd = '{mode: mode_prom, kind: r_slot_q.kind, gen: r_slot_q.gen};
            end else begin
                slot_wd = '{mode: MODE_FREE, kind: '0, gen: gen_rel};
            end
        end

        slot_re = i_cmd.rd_slot || i_cmd.found;
        slot_ra = i_cmd.found ? found_num[IDX_W-1:0] : in_idx[IDX_W-1:0];

        bmp_we = 1'b0;
        bmp_wa = WRD_W'(r_num >> 5);
        bmp_wd = r_bmp_q;
        if (i_cmd.clr) begin
            bmp_we = (32'(r_clr) < 32'(WORDS));
            bmp_wa = WRD_W'(r_clr);
            bmp_wd = '0;
        end else if (i_cmd.fin_alloc) begin
            bmp_we = 1'b1;
            bmp_wd = r_bmp_q | num_bit;
        end else if (exec_wr && r_op == OP_RELEASE) begin
            bmp_we = 1'b1;
            bmp_wd = r_bmp_q & ~num_bit;
        end

        bmp_re = i_cmd.rd_hint || i_cmd.scan_next || i_cmd.rd_slot;
        priority if (i_cmd.rd_hint) bmp_ra = r_hint[WRD_W-1:0];
        else if (i_cmd.scan_next) bmp_ra = scan_inc[WRD_W-1:0];
        else bmp_ra = WRD_W'(in_idx >> 5);
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) m_slot[slot_wa] <= slot_wd;
        if (slot_re) r_slot_q <= m_slot[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bmp_we) m_bmp[bmp_wa] <= bmp_wd;
        if (bmp_re) r_bmp_q <= m_bmp[bmp_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_hint      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + IDX_W'(1);
            if (i_cmd.rd_hint) r_scan <= r_hint;
            else if (i_cmd.scan_next) r_scan <= scan_inc;
            if (i_cmd.fin_alloc) begin
                r_hint <= r_scan;
            end else if (exec_wr && r_op == OP_RELEASE && num_wrd < r_hint) begin
                r_hint <= num_wrd;
            end
            if (i_cmd.fin_alloc || i_cmd.fin_exec || i_cmd.fin_plain) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_op;
            r_gen    <= in_gen;
            r_kind   <= i_kind;
            r_hvalid <= in_hvalid;
            r_num    <= in_idx;
        end else if (i_cmd.found) begin
            r_num <= found_num;
        end

        if (i_cmd.fin_alloc) begin
            r_out_status <= 1'b0;
            r_out_handle <= {gen_alloc, r_num + NUM_W'(1)};
            r_out_num    <= r_num;
            r_out_mode   <= MODE_RESERVED;
        end else if (i_cmd.fin_exec) begin
            r_out_handle <= '0;
            if (match) begin
                r_out_status <= 1'b0;
                r_out_num    <= r_num;
                unique case (r_op)
                    OP_PROMOTE: r_out_mode <= mode_prom;
                    OP_RELEASE: r_out_mode <= MODE_FREE;
                    default:    r_out_mode <= r_slot_q.mode;
                endcase
            end else begin
                r_out_status <= 1'b1;
                r_out_num    <= NONE_NUM;
                r_out_mode   <= MODE_FREE;
            end
        end else if (i_cmd.fin_plain) begin
            r_out_handle <= '0;
            r_out_mode   <= MODE_FREE;
            if (r_op == OP_DECODE && r_hvalid) begin
                r_out_status <= 1'b0;
                r_out_num    <= r_num;
            end else begin
                r_out_status <= 1'b1;
                r_out_num    <= NONE_NUM;
            end
        end
    end

    always_comb begin
        o_sts.clr_last     = (r_clr == IDX_W'(SLOT_COUNT - 1));
        o_sts.in_hvalid    = in_hvalid;
        o_sts.in_kind_zero = (i_kind == '0);
        o_sts.scan_hit     = |scan_free;
        o_sts.scan_last    = (scan_inc == SCN_W'(WORDS));
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_new_handle  = r_out_handle;
    assign o_slot_number = r_out_num;
    assign o_slot_status = r_out_mode;

endmodule

// File: bench/tb_generational_handle_table.sv
module tb_generational_handle_table import ght_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200_000;

    // opcodes the block does not define, still part of the input space
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] new_handle;
        logic [NUM_W-1:0]    slot_number;
        logic [MODE_W-1:0]   slot_status;
    } t_op_result;

    typedef struct packed {
        logic [HANDLE_W-1:0] h;
        logic [KIND_W-1:0]   kind;
    } t_stale_ref;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // handle[31:0], object_kind[39:32]
    logic [OP_W-1:0]       s_axis_tuser;   // opcode[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // new_handle[31:0], slot_number[47:32], slot_status[49:48]
    logic [0:0]            m_axis_tuser;   // status[0]

    // shadow copy of the slot table
    logic [MODE_W-1:0] tbl_mode [SLOTS];
    logic [KIND_W-1:0] tbl_kind [SLOTS];
    logic [GEN_W-1:0]  tbl_gen  [SLOTS];

    t_op_result expected_results [$];
    t_stale_ref old_handles [$];

    int  in_use;
    int  items_sent;
    int  results_checked;
    int  mismatches;
    int  full_table_hits;
    int  cycle_count;
    int  hold_len;
    bit  tx_gaps;
    bit  rx_stalls;

    generational_handle_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [HANDLE_W-1:0] slot_handle(input int i);
        return {tbl_gen[i], NUM_W'(i + 1)};
    endfunction

    // applies one operation to the shadow table and returns what the block should answer
    function automatic t_op_result table_apply(input logic [OP_W-1:0] op,
                                               input logic [HANDLE_W-1:0] h,
                                               input logic [KIND_W-1:0] kind);
        t_op_result r;
        int         idx;
        logic       valid;
        logic       hit;
        r.status      = 1'b1;
        r.new_handle  = '0;
        r.slot_number = NUM_W'(SLOTS);
        r.slot_status = MODE_FREE;
        idx   = int'(h[15:0]) - 1;
        valid = (h[15:0] != 16'd0) && (int'(h[15:0]) <= SLOTS) && (h[31:16] != 16'd0);
        hit   = 1'b0;
        if (valid) begin
            hit = (tbl_mode[idx] != MODE_FREE) && (tbl_gen[idx] == h[31:16]) &&
                  (tbl_kind[idx] == kind);
        end
        case (op)
            OP_ALLOC: begin
                if (kind != '0) begin
                    idx = 0;
                    while (idx < SLOTS && tbl_mode[idx] != MODE_FREE) idx++;
                    if (idx < SLOTS) begin
                        if (tbl_gen[idx] == '0) tbl_gen[idx] = 16'd1;
                        tbl_kind[idx] = kind;
                        tbl_mode[idx] = MODE_RESERVED;
                        in_use++;
                        r.status      = 1'b0;
                        r.new_handle  = slot_handle(idx);
                        r.slot_number = NUM_W'(idx);
                        r.slot_status = MODE_RESERVED;
                    end else begin
                        full_table_hits++;
                    end
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    r.status      = 1'b0;
                    r.slot_number = NUM_W'(idx);
                    r.slot_status = tbl_mode[idx];
                end
            end
            OP_PROMOTE: begin
                if (hit) begin
                    if (tbl_mode[idx] == MODE_RESERVED) tbl_mode[idx] = MODE_LIVE;
                    r.status      = 1'b0;
                    r.slot_number = NUM_W'(idx);
                    r.slot_status = tbl_mode[idx];
                end
            end
            OP_RELEASE: begin
                if (hit) begin
                    tbl_mode[idx] = MODE_FREE;
                    tbl_kind[idx] = '0;
                    // generation skips zero when it wraps
                    if (tbl_gen[idx] == 16'hffff) begin
                        tbl_gen[idx] = 16'd1;
                    end else begin
                        tbl_gen[idx] = tbl_gen[idx] + 16'd1;
                    end
                    in_use--;
                    old_handles.push_back('{h: h, kind: kind});
                    if (old_handles.size() > 16) void'(old_handles.pop_front());
                    r.status      = 1'b0;
                    r.slot_number = NUM_W'(idx);
                    r.slot_status = MODE_FREE;
                end
            end
            OP_DECODE: begin
                if (valid) begin
                    r.status      = 1'b0;
                    r.slot_number = NUM_W'(idx);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_used_slot();
        int start;
        int i;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            i = (start + k) % SLOTS;
            if (tbl_mode[i] != MODE_FREE) return i;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d, %s: got %0h, expected %0h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_op_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("beat with nothing pending", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser[0] !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser[0]), 32'(want.status));
                if (m_axis_tdata[31:0] !== want.new_handle)
                    report_mismatch("new_handle", m_axis_tdata[31:0], want.new_handle);
                if (m_axis_tdata[47:32] !== want.slot_number)
                    report_mismatch("slot_number", 32'(m_axis_tdata[47:32]),
                                    32'(want.slot_number));
                if (m_axis_tdata[49:48] !== want.slot_status)
                    report_mismatch("slot_status", 32'(m_axis_tdata[49:48]),
                                    32'(want.slot_status));
                results_checked++;
            end
        end
    end

    // result receiver: random stalls after each beat, long hold-off on request
    initial begin
        int wait_n;
        wait_n = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) wait_n = rx_stalls ? $urandom_range(0, 5) : 0;
            if (hold_len > 0) begin
                wait_n   = hold_len;
                hold_len = 0;
            end
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                wait_n--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                             input logic [KIND_W-1:0] kind);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {kind, h};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_results.push_back(table_apply(op, h, kind));
        items_sent++;
    endtask

    // sender pauses until every pending result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic free_all_slots();
        for (int i = 0; i < SLOTS; i++)
            if (tbl_mode[i] != MODE_FREE) send_item(OP_RELEASE, slot_handle(i), tbl_kind[i]);
        wait_idle();
    endtask

    task automatic test_directed();
        logic [HANDLE_W-1:0] h0;
        logic [HANDLE_W-1:0] h1;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_item(OP_ALLOC, '0, 8'h00);               // no kind: refused
        send_item(OP_ALLOC, 32'hffff_ffff, 8'hff);
        send_item(OP_ALLOC, '0, 8'h01);
        h0 = slot_handle(0);
        h1 = slot_handle(1);
        send_item(OP_LOOKUP, h0, 8'hff);
        send_item(OP_LOOKUP, h0, 8'h01);              // wrong kind
        send_item(OP_LOOKUP, {h0[31:16] + 16'd1, h0[15:0]}, 8'hff);
        send_item(OP_LOOKUP, '0, 8'h00);
        send_item(OP_LOOKUP, {16'h0001, 16'h0000}, 8'hff);
        send_item(OP_PROMOTE, h0, 8'hff);
        send_item(OP_PROMOTE, h0, 8'hff);             // already live
        send_item(OP_LOOKUP, h0, 8'hff);
        send_item(OP_PROMOTE, h1, 8'hfe);
        send_item(OP_RELEASE, h1, 8'h01);             // release while reserved
        send_item(OP_LOOKUP, h1, 8'h01);              // stale generation
        send_item(OP_RELEASE, h1, 8'h01);
        send_item(OP_ALLOC, '0, 8'h80);
        send_item(OP_DECODE, {16'hffff, NUM_W'(SLOTS)}, 8'h00);
        send_item(OP_DECODE, {16'h0001, NUM_W'(SLOTS + 1)}, 8'h00);
        send_item(OP_DECODE, {16'h0000, 16'h0005}, 8'h00);
        send_item(OP_DECODE, 32'hffff_ffff, 8'hff);
        send_item(OP_SPARE_5, h0, 8'hff);
        send_item(OP_SPARE_6, h0, 8'hff);
        send_item(OP_SPARE_7, h0, 8'hff);
        send_item(OP_RELEASE, h0, 8'hff);
        send_item(OP_PROMOTE, h0, 8'hff);
        free_all_slots();
    endtask

    task automatic test_full_table();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (SLOTS) send_item(OP_ALLOC, $urandom(), KIND_W'($urandom_range(1, 255)));
        send_item(OP_ALLOC, '0, 8'h5a);               // table full
        send_item(OP_LOOKUP, slot_handle(SLOTS - 1), tbl_kind[SLOTS - 1]);
        send_item(OP_PROMOTE, slot_handle(SLOTS - 1), tbl_kind[SLOTS - 1]);
        send_item(OP_RELEASE, slot_handle(200), tbl_kind[200]);
        send_item(OP_RELEASE, slot_handle(40), tbl_kind[40]);
        send_item(OP_RELEASE, slot_handle(SLOTS - 1), tbl_kind[SLOTS - 1]);
        // the holes fill back lowest first
        repeat (3) send_item(OP_ALLOC, '0, 8'h33);
        send_item(OP_ALLOC, '0, 8'h34);
        free_all_slots();
    endtask

    task automatic test_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_len  = 300;
        for (int n = 0; n < 30; n++) begin
            case (n % 3)
                0: send_item(OP_ALLOC, '0, KIND_W'($urandom_range(1, 255)));
                1: send_item(OP_LOOKUP, slot_handle(n / 3), tbl_kind[n / 3]);
                default: send_item(OP_DECODE, $urandom(), 8'h00);
            endcase
        end
        wait_idle();
        rx_stalls = 1'b1;
        for (int n = 0; n < 10; n++) send_item(OP_PROMOTE, slot_handle(n), tbl_kind[n]);
        free_all_slots();
    endtask

    task automatic random_item();
        int                  pick;
        int                  s;
        int                  r;
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] h;
        logic [KIND_W-1:0]   k;
        t_stale_ref          st;
        pick = $urandom_range(0, 99);
        s    = pick_used_slot();
        if (pick < 30 && !(in_use > 96 && $urandom_range(0, 1) == 1)) begin
            k = ($urandom_range(0, 15) == 0) ? '0 : KIND_W'($urandom_range(1, 255));
            send_item(OP_ALLOC, $urandom(), k);
        end else if (pick < 72 && s >= 0) begin
            h = slot_handle(s);
            k = tbl_kind[s];
            r = $urandom_range(0, 99);
            if (r < 8) k = k ^ KIND_W'($urandom_range(1, 255));
            else if (r < 14) h[31:16] = h[31:16] + GEN_W'($urandom_range(1, 3));
            r  = $urandom_range(0, 99);
            op = (r < (in_use > 96 ? 55 : 25)) ? OP_RELEASE :
                 (r < 65) ? OP_PROMOTE : OP_LOOKUP;
            send_item(op, h, k);
        end else if (pick < 80 && old_handles.size() > 0) begin
            st = old_handles[$urandom_range(0, old_handles.size() - 1)];
            r  = $urandom_range(0, 2);
            op = (r == 0) ? OP_LOOKUP : (r == 1) ? OP_PROMOTE : OP_RELEASE;
            send_item(op, st.h, st.kind);
        end else if (pick < 88) begin
            h = {GEN_W'($urandom()), NUM_W'($urandom_range(0, SLOTS + 40))};
            send_item(OP_DECODE, h, KIND_W'($urandom_range(0, 255)));
        end else begin
            send_item(OP_W'($urandom_range(0, 7)), $urandom(), KIND_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random();
        for (int b = 0; b < 9; b++) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            repeat (50) random_item();
            if (b == 4) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_len      = 0;
        tx_gaps       = 1'b0;
        rx_stalls     = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_mode[i] = MODE_FREE;
            tbl_kind[i] = '0;
            tbl_gen[i]  = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_backpressure();
        test_random();

        $display("sent %0d items, checked %0d results, full table hit %0d times",
                 items_sent, results_checked, full_table_hits);
        $display("directed cases, full table, long output hold-off, drain pauses and random mixes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
